[src/smpd_pkg.sv]
// Shared types and constants for the serial mouse packet decoder.
`default_nettype none

package smpd_pkg;

    localparam int BYTE_W = 8;
    localparam int DELTA_W = 8;
    localparam int SENS_W = 8;
    localparam int PROD_W = DELTA_W + SENS_W + 1;
    localparam int BTN_W = 3;
    localparam int OUT_POS_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
    localparam logic [OP_W-1:0] OP_HEADER = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_MIDDLE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [1:0]               lr;
        logic                     mid;
        logic signed [PROD_W-1:0] dx;
        logic signed [PROD_W-1:0] dy;
    } t_cmd;

endpackage

`default_nettype wire

[src/smpd_front.sv]
// Front end: tracks the byte position, stores packet bytes and scales the deltas.
`default_nettype none

module smpd_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    input  wire  [smpd_pkg::SENS_W-1:0]         i_cfg_data,
    input  wire                                 i_rx_valid,
    input  wire  [smpd_pkg::BYTE_W-1:0]         i_rx_byte,
    input  wire                                 i_full,
    output logic                                o_rx_stall,
    output logic                                o_push,
    output smpd_pkg::t_cmd                      o_cmd
);

    localparam logic [2:0] POS_HEADER = 3'd0;
    localparam logic [2:0] POS_SECOND = 3'd1;
    localparam logic [2:0] POS_THIRD  = 3'd2;
    localparam logic [2:0] POS_FOURTH = 3'd3;
    localparam logic [2:0] POS_LONG   = 3'd4;

    logic [2:0]                     r_pos;
    logic [2:0]                     n_pos;
    logic [smpd_pkg::BYTE_W-1:0]    r_header;
    logic [smpd_pkg::BYTE_W-1:0]    r_second;
    logic [smpd_pkg::SENS_W-1:0]    r_sens;
    logic [2:0]                     w_pos;
    logic signed [smpd_pkg::DELTA_W-1:0] w_dx;
    logic signed [smpd_pkg::DELTA_W-1:0] w_dy;
    logic signed [smpd_pkg::SENS_W:0]    w_sens;

    assign o_rx_stall = i_full;
    assign o_push     = i_rx_valid && !i_full;
    assign w_pos      = i_rx_byte[6] ? POS_HEADER : r_pos;
    assign n_pos      = (w_pos == POS_LONG) ? POS_LONG : w_pos + 3'd1;

    assign w_dx   = {r_header[1:0], r_second[5:0]};
    assign w_dy   = {r_header[3:2], i_rx_byte[5:0]};
    assign w_sens = {1'b0, r_sens};

    always_comb begin
        o_cmd.op  = smpd_pkg::OP_NONE;
        o_cmd.lr  = i_rx_byte[5:4];
        o_cmd.mid = i_rx_byte[5];
        o_cmd.dx  = smpd_pkg::PROD_W'(w_dx) * smpd_pkg::PROD_W'(w_sens);
        o_cmd.dy  = smpd_pkg::PROD_W'(w_dy) * smpd_pkg::PROD_W'(w_sens);
        unique case (w_pos)
            POS_HEADER: o_cmd.op = smpd_pkg::OP_HEADER;
            POS_SECOND: o_cmd.op = smpd_pkg::OP_NONE;
            POS_THIRD:  o_cmd.op = smpd_pkg::OP_MOVE;
            POS_FOURTH: o_cmd.op = smpd_pkg::OP_MIDDLE;
            default:    o_cmd.op = smpd_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HEADER;
            r_header <= '0;
            r_second <= '0;
            r_sens   <= smpd_pkg::SENS_W'(1);
        end else begin
            if (i_cfg_valid) begin
                r_sens <= i_cfg_data;
            end
            if (o_push) begin
                r_pos <= n_pos;
                if (w_pos == POS_HEADER) begin
                    r_header <= i_rx_byte;
                end
                if (w_pos == POS_SECOND) begin
                    r_second <= i_rx_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/smpd_fifo.sv]
// Short command queue between the front end and the back end.
`default_nettype none

module smpd_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  smpd_pkg::t_cmd      i_cmd,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_empty,
    output smpd_pkg::t_cmd      o_cmd
);

    localparam logic [smpd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        smpd_pkg::QUEUE_CNT_W'(smpd_pkg::QUEUE_DEPTH);
    localparam logic [smpd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        smpd_pkg::QUEUE_PTR_W'(smpd_pkg::QUEUE_DEPTH - 1);

    smpd_pkg::t_cmd                      r_mem [smpd_pkg::QUEUE_DEPTH];
    logic [smpd_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [smpd_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [smpd_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic                                w_push;
    logic                                w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command queue written while full");

endmodule

`default_nettype wire

[src/smpd_back.sv]
// Back end: applies queued commands to the buttons and position accumulators.
`default_nettype none

module smpd_back #(
    parameter int POSITION_WIDTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_empty,
    input  smpd_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    input  wire                                 i_res_stall,
    output logic                                o_res_valid,
    output logic [smpd_pkg::BTN_W-1:0]          o_buttons,
    output logic signed [smpd_pkg::OUT_POS_W-1:0] o_pos_x,
    output logic signed [smpd_pkg::OUT_POS_W-1:0] o_pos_y,
    output logic                                o_packet_done
);

    logic [smpd_pkg::BTN_W-1:0]     r_buttons;
    logic [POSITION_WIDTH-1:0]      r_acc_x;
    logic [POSITION_WIDTH-1:0]      r_acc_y;
    logic                           r_done;
    logic                           r_valid;
    logic [POSITION_WIDTH-1:0]      w_dx_ext;
    logic [POSITION_WIDTH-1:0]      w_dy_ext;

    generate
        if (POSITION_WIDTH > smpd_pkg::PROD_W) begin : g_ext
            assign w_dx_ext = {{(POSITION_WIDTH - smpd_pkg::PROD_W){i_cmd.dx[smpd_pkg::PROD_W-1]}},
                               i_cmd.dx};
            assign w_dy_ext = {{(POSITION_WIDTH - smpd_pkg::PROD_W){i_cmd.dy[smpd_pkg::PROD_W-1]}},
                               i_cmd.dy};
        end else begin : g_trunc
            assign w_dx_ext = i_cmd.dx[POSITION_WIDTH-1:0];
            assign w_dy_ext = i_cmd.dy[POSITION_WIDTH-1:0];
        end
        if (POSITION_WIDTH >= smpd_pkg::OUT_POS_W) begin : g_out_wide
            assign o_pos_x = r_acc_x[smpd_pkg::OUT_POS_W-1:0];
            assign o_pos_y = r_acc_y[smpd_pkg::OUT_POS_W-1:0];
        end else begin : g_out_narrow
            assign o_pos_x = {{(smpd_pkg::OUT_POS_W - POSITION_WIDTH){1'b0}}, r_acc_x};
            assign o_pos_y = {{(smpd_pkg::OUT_POS_W - POSITION_WIDTH){1'b0}}, r_acc_y};
        end
    endgenerate

    assign o_pop         = !i_empty && (!r_valid || !i_res_stall);
    assign o_res_valid   = r_valid;
    assign o_buttons     = r_buttons;
    assign o_packet_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_done    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_done  <= (i_cmd.op == smpd_pkg::OP_MOVE);
                unique case (i_cmd.op)
                    smpd_pkg::OP_HEADER: r_buttons[1:0] <= i_cmd.lr;
                    smpd_pkg::OP_MOVE: begin
                        r_acc_x <= r_acc_x + w_dx_ext;
                        r_acc_y <= r_acc_y + w_dy_ext;
                    end
                    smpd_pkg::OP_MIDDLE: r_buttons[2] <= i_cmd.mid;
                    default: r_buttons <= r_buttons;
                endcase
            end else if (!i_res_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_done_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_cmd.op == smpd_pkg::OP_MOVE) |=> o_res_valid && o_packet_done)
        else $error("movement command did not produce a done result");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_cmd.op != smpd_pkg::OP_MOVE) |=> $stable(r_acc_x) && $stable(r_acc_y))
        else $error("position changed without a movement command");

    a_middle_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_cmd.op == smpd_pkg::OP_HEADER) |=> $stable(r_buttons[2]))
        else $error("header changed the middle button");

    a_middle_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_cmd.op == smpd_pkg::OP_MIDDLE) |=> r_buttons[2] == $past(i_cmd.mid))
        else $error("fourth byte did not update the middle button");

endmodule

`default_nettype wire

[src/serial_mouse_packet_decoder.sv]
// Top level of the serial mouse packet decoder.
// The receive channel (i_rx_valid, i_rx_byte, o_rx_stall) takes one byte
// from the serial mouse per transfer. Every byte gives exactly one result
// transfer on the output channel (o_res_valid, buttons, positions and
// o_packet_done, with i_res_stall from the receiver).
// A byte with bit 6 set starts a packet; the third byte of a packet moves
// the X and Y positions by the deltas times the sensitivity and flags
// o_packet_done, and a fourth byte sets the middle button.
// The configuration channel (i_cfg_valid, i_cfg_data, o_cfg_ready) writes
// the sensitivity and is always ready; write it only while no result is
// pending.
// A result is registered after its byte is accepted: the byte enters
// the two-entry command queue when accepted and the back end registers
// the result when it takes the command from the queue.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result holds, the queue fills and then
// o_rx_stall rises until a result is taken.
// Reset clears the packet state, buttons and positions and sets the
// sensitivity to one.
`default_nettype none

module serial_mouse_packet_decoder #(
    parameter int POSITION_WIDTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [smpd_pkg::SENS_W-1:0]         i_cfg_data,
    input  wire                                 i_rx_valid,
    output logic                                o_rx_stall,
    input  wire  [smpd_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_res_valid,
    input  wire                                 i_res_stall,
    output logic [smpd_pkg::BTN_W-1:0]          o_buttons,
    output logic signed [smpd_pkg::OUT_POS_W-1:0] o_pos_x,
    output logic signed [smpd_pkg::OUT_POS_W-1:0] o_pos_y,
    output logic                                o_packet_done
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    smpd_pkg::t_cmd w_cmd_in;
    smpd_pkg::t_cmd w_cmd_out;

    assign o_cfg_ready = 1'b1;

    smpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .i_full      (w_full),
        .o_rx_stall  (o_rx_stall),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    smpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    smpd_back #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_cmd         (w_cmd_out),
        .o_pop         (w_pop),
        .i_res_stall   (i_res_stall),
        .o_res_valid   (o_res_valid),
        .o_buttons     (o_buttons),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_packet_done (o_packet_done)
    );

endmodule

`default_nettype wire
